// ===== rtl/frac_pkg.sv =====
// Package for the fraction add-and-reduce block: width default, controller
// states, datapath select codes and the command/status bundles.
// Depends on nothing; the controller, datapath, top level and checker import it.
`default_nettype none

package frac_pkg;

    // Default operand width (bits of each two's complement input field)
    localparam int FRAC_OPERAND_WIDTH = 16;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_T1,
        ST_MUL_T2,
        ST_MUL_DEN,
        ST_SUM,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_RESULT
    } t_state;

    // Operand pair routed to the shared multiplier
    typedef enum logic [1:0] {
        MUL_T1,
        MUL_T2,
        MUL_DEN
    } t_mul_sel;

    // Dividend source and quotient destination of the serial divider
    typedef enum logic [0:0] {
        DIV_NUM,
        DIV_DEN
    } t_div_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum_load;
        logic     gcd_step;
        logic     div_load;
        t_div_sel div_src;
        logic     div_step;
        logic     div_store;
        t_div_sel store_sel;
        logic     res_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic den_err;
        logic gcd_zero;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/frac_if.sv =====
// Valid/ready channel interfaces for operand and result transfers.
// Stand-alone; widths follow the OPERAND_WIDTH parameter.
`default_nettype none

interface frac_in_if #(
    parameter int OPERAND_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [OPERAND_WIDTH-1:0] num_a;
    logic signed [OPERAND_WIDTH-1:0] den_a;
    logic signed [OPERAND_WIDTH-1:0] num_b;
    logic signed [OPERAND_WIDTH-1:0] den_b;

    modport source (output valid, num_a, den_a, num_b, den_b, input ready);
    modport sink   (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

interface frac_out_if #(
    parameter int OPERAND_WIDTH = 16
);
    logic                       valid;
    logic                       ready;
    logic                       negative;
    logic [2*OPERAND_WIDTH-2:0] num_mag;
    logic [2*OPERAND_WIDTH-3:0] den_mag;
    logic                       den_error;

    modport source (output valid, negative, num_mag, den_mag, den_error, input ready);
    modport sink   (input valid, negative, num_mag, den_mag, den_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/frac_ctrl.sv =====
// Controller for the fraction add-and-reduce block: sequences multiply,
// sum, binary gcd and two serial divisions, and owns the result valid flag.
// Depends on frac_pkg.
`default_nettype none

module frac_ctrl #(
    parameter int OPERAND_WIDTH = frac_pkg::FRAC_OPERAND_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire frac_pkg::t_status i_status,
    output frac_pkg::t_cmd        o_cmd
);
    import frac_pkg::*;

    localparam int PROD_W = 2 * OPERAND_WIDTH;
    localparam int CNT_W  = $clog2(PROD_W);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_cnt_last;
    logic             w_out_free;
    t_cmd             w_cmd;

    assign w_cnt_last = (r_cnt == CNT_W'(PROD_W - 1));
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_MUL_T1;
            ST_MUL_T1:  n_state = i_status.den_err ? ST_RESULT : ST_MUL_T2;
            ST_MUL_T2:  n_state = ST_MUL_DEN;
            ST_MUL_DEN: n_state = ST_SUM;
            ST_SUM:     n_state = ST_GCD;
            ST_GCD:     if (i_status.gcd_zero) n_state = ST_DIV_NUM;
            ST_DIV_NUM: if (w_cnt_last) n_state = ST_DIV_DEN;
            ST_DIV_DEN: if (w_cnt_last) n_state = ST_RESULT;
            ST_RESULT:  if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Commands per state
    always_comb begin
        w_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_cmd.load_in = i_in_valid;
            end
            ST_MUL_T1: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_T1;
            end
            ST_MUL_T2: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_T2;
            end
            ST_MUL_DEN: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_DEN;
            end
            ST_SUM: begin
                w_cmd.sum_load = 1'b1;
            end
            ST_GCD: begin
                if (i_status.gcd_zero) begin
                    w_cmd.div_load = 1'b1;
                    w_cmd.div_src  = DIV_NUM;
                end else begin
                    w_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV_NUM: begin
                w_cmd.div_step = 1'b1;
                if (w_cnt_last) begin
                    w_cmd.div_store = 1'b1;
                    w_cmd.store_sel = DIV_NUM;
                    w_cmd.div_load  = 1'b1;
                    w_cmd.div_src   = DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                w_cmd.div_step = 1'b1;
                if (w_cnt_last) begin
                    w_cmd.div_store = 1'b1;
                    w_cmd.store_sel = DIV_DEN;
                end
            end
            ST_RESULT: begin
                w_cmd.res_load = w_out_free;
            end
            default: w_cmd = '0;
        endcase
    end

    // Divider step count and result valid
    always_comb begin
        n_cnt = r_cnt;
        if (w_cmd.div_load) begin
            n_cnt = '0;
        end else if (w_cmd.div_step) begin
            n_cnt = r_cnt + 1'b1;
        end
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

// ===== rtl/frac_dp.sv =====
// Datapath for the fraction add-and-reduce block: operand magnitudes, shared
// multiplier, signed sum, binary gcd, restoring divider and result register.
// Depends on frac_pkg; driven by frac_ctrl.
`default_nettype none

module frac_dp #(
    parameter int OPERAND_WIDTH = frac_pkg::FRAC_OPERAND_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire frac_pkg::t_cmd                  i_cmd,
    output frac_pkg::t_status                    o_status,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_num_a,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_den_a,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_num_b,
    input  wire logic signed [OPERAND_WIDTH-1:0] i_den_b,
    output logic                                 o_negative,
    output logic [2*OPERAND_WIDTH-2:0]           o_num_mag,
    output logic [2*OPERAND_WIDTH-3:0]           o_den_mag,
    output logic                                 o_den_error
);
    import frac_pkg::*;

    localparam int W      = OPERAND_WIDTH;
    localparam int PROD_W = 2 * OPERAND_WIDTH;
    localparam int NUM_W  = PROD_W - 1;
    localparam int DEN_W  = PROD_W - 2;

    // Magnitude of a two's complement field; the most negative code keeps
    // its true magnitude in W unsigned bits
    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [W-1:0]      r_na, r_da, r_nb, r_db;
    logic              r_neg_a, r_neg_b, r_err;
    logic [PROD_W-1:0] r_t1, r_t2, r_den;
    logic [PROD_W-1:0] r_x, r_y, r_num, r_dnm;
    logic [PROD_W-1:0] n_x, n_y, n_num, n_dnm;
    logic              r_neg;
    logic [PROD_W-1:0] r_rem, r_quo, n_rem, n_quo;
    logic [NUM_W-1:0]  r_rn;
    logic [DEN_W-1:0]  r_rd;

    logic [W-1:0]      w_na, w_da, w_nb, w_db;
    logic [W-1:0]      w_op_a, w_op_b;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_sum;
    logic              w_sum_neg;
    logic [PROD_W:0]   w_trial;
    logic [PROD_W:0]   w_trial_diff;

    // Capture operand magnitudes and signs on accept
    assign w_na = mag_of(i_num_a);
    assign w_da = mag_of(i_den_a);
    assign w_nb = mag_of(i_num_b);
    assign w_db = mag_of(i_den_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_na    <= w_na;
            r_da    <= w_da;
            r_nb    <= w_nb;
            r_db    <= w_db;
            r_neg_a <= (w_na != '0) && (i_num_a[W-1] != i_den_a[W-1]);
            r_neg_b <= (w_nb != '0) && (i_num_b[W-1] != i_den_b[W-1]);
            r_err   <= (w_da == '0) || (w_db == '0);
        end
    end

    // Shared multiplier, one product per cycle
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_T1: begin
                w_op_a = r_na;
                w_op_b = r_db;
            end
            MUL_T2: begin
                w_op_a = r_nb;
                w_op_b = r_da;
            end
            MUL_DEN: begin
                w_op_a = r_da;
                w_op_b = r_db;
            end
            default: begin
                w_op_a = r_da;
                w_op_b = r_db;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_op_a) * PROD_W'(w_op_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_T1:  r_t1  <= w_prod;
                MUL_T2:  r_t2  <= w_prod;
                default: r_den <= w_prod;
            endcase
        end
    end

    // Signed sum of the cross products in sign-magnitude form
    always_comb begin
        if (r_neg_a == r_neg_b) begin
            w_sum     = r_t1 + r_t2;
            w_sum_neg = r_neg_a;
        end else if (r_t1 >= r_t2) begin
            w_sum     = r_t1 - r_t2;
            w_sum_neg = r_neg_a;
        end else begin
            w_sum     = r_t2 - r_t1;
            w_sum_neg = r_neg_b;
        end
    end

    // Binary gcd: shared powers of two are stripped from the working pair
    // and from the copies of numerator and denominator alike, so the
    // gcd left in r_y divides those copies exactly
    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_num = r_num;
        n_dnm = r_dnm;
        if (i_cmd.sum_load) begin
            n_x   = w_sum;
            n_y   = r_den;
            n_num = w_sum;
            n_dnm = r_den;
        end else if (i_cmd.gcd_step) begin
            if (!r_x[0] && !r_y[0]) begin
                n_x   = r_x >> 1;
                n_y   = r_y >> 1;
                n_num = r_num >> 1;
                n_dnm = r_dnm >> 1;
            end else if (!r_x[0]) begin
                n_x = r_x >> 1;
            end else if (!r_y[0]) begin
                n_y = r_y >> 1;
            end else if (r_x >= r_y) begin
                n_x = (r_x - r_y) >> 1;
            end else begin
                n_y = (r_y - r_x) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_num <= n_num;
        r_dnm <= n_dnm;
        if (i_cmd.sum_load) begin
            r_neg <= w_sum_neg && (w_sum != '0);
        end
    end

    // Restoring divider, one quotient bit per cycle, divisor is the gcd
    assign w_trial      = {r_rem, r_quo[PROD_W-1]};
    assign w_trial_diff = w_trial - {1'b0, r_y};

    always_comb begin
        if (!w_trial_diff[PROD_W]) begin
            n_rem = w_trial_diff[PROD_W-1:0];
            n_quo = {r_quo[PROD_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[PROD_W-1:0];
            n_quo = {r_quo[PROD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_quo <= (i_cmd.div_src == DIV_NUM) ? r_num : r_dnm;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Store the final quotient, saturating to the field width
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            if (i_cmd.store_sel == DIV_NUM) begin
                r_rn <= n_quo[PROD_W-1] ? {NUM_W{1'b1}} : n_quo[NUM_W-1:0];
            end else begin
                r_rd <= (|n_quo[PROD_W-1:DEN_W]) ? {DEN_W{1'b1}} : n_quo[DEN_W-1:0];
            end
        end
    end

    // Result register, zero payload on a zero denominator
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_negative  <= r_err ? 1'b0 : r_neg;
            o_num_mag   <= r_err ? '0 : r_rn;
            o_den_mag   <= r_err ? '0 : r_rd;
            o_den_error <= r_err;
        end
    end

    assign o_status.den_err  = r_err;
    assign o_status.gcd_zero = (r_x == '0);

endmodule

`default_nettype wire

// ===== rtl/fraction_add_reduce.sv =====
// Top level of the fraction add-and-reduce block: joins controller and
// datapath to the operand and result channels.
// Depends on frac_pkg, frac_if, frac_ctrl and frac_dp.
//
//   channel     dir  modport  payload
//   i_operands  in   sink     num_a, den_a, num_b, den_b (signed, OPERAND_WIDTH)
//   o_result    out  source   negative, num_mag, den_mag, den_error
//
// One operand transfer at a time. An item is accepted, takes three products
// on the shared multiplier, is summed, is reduced by binary gcd steps and
// is divided by the gcd twice, numerator then denominator, before its result
// is loaded; a zero denominator skips from the first multiply to the result.
// Reset is synchronous and active low and clears controller state only.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits for that register before its own result is loaded.
`default_nettype none

module fraction_add_reduce #(
    parameter int OPERAND_WIDTH = frac_pkg::FRAC_OPERAND_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    frac_in_if.sink     i_operands,
    frac_out_if.source  o_result
);
    import frac_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    frac_ctrl #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_operands.valid),
        .o_in_ready  (i_operands.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    frac_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_num_a     (i_operands.num_a),
        .i_den_a     (i_operands.den_a),
        .i_num_b     (i_operands.num_b),
        .i_den_b     (i_operands.den_b),
        .o_negative  (o_result.negative),
        .o_num_mag   (o_result.num_mag),
        .o_den_mag   (o_result.den_mag),
        .o_den_error (o_result.den_error)
    );

endmodule

`default_nettype wire

// ===== rtl/frac_checker.sv =====
// Port-level checks for fraction_add_reduce, attached by the bind below.
// Depends on frac_pkg and the top level's result channel.
`default_nettype none

module frac_checker #(
    parameter int OPERAND_WIDTH = frac_pkg::FRAC_OPERAND_WIDTH
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       i_ready,
    input wire logic                       i_negative,
    input wire logic [2*OPERAND_WIDTH-2:0] i_num_mag,
    input wire logic [2*OPERAND_WIDTH-3:0] i_den_mag,
    input wire logic                       i_den_error
);
    import frac_pkg::*;

    // Hold a result until it is taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped before transfer");

    // Zero denominator gives an all-zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_den_error |-> !i_negative && i_num_mag == '0 && i_den_mag == '0)
        else $error("error result carries a non-zero payload");

    // A valid sum always has a positive denominator
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_den_error |-> i_den_mag != '0)
        else $error("zero denominator without error flag");

    // Zero sum reduces to positive 0/1
    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_den_error && i_num_mag == '0 |-> !i_negative && i_den_mag == 1)
        else $error("zero sum not reduced to 0/1");

endmodule

bind fraction_add_reduce frac_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_frac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_result.valid),
    .i_ready     (o_result.ready),
    .i_negative  (o_result.negative),
    .i_num_mag   (o_result.num_mag),
    .i_den_mag   (o_result.den_mag),
    .i_den_error (o_result.den_error)
);

`default_nettype wire

// ===== test/tb_fraction_add_reduce.sv =====
// Testbench for fraction_add_reduce: drives operand pairs with random idling on both channels
// and checks every result against a behavioural model of the sum reduced to lowest terms.
// Depends on frac_pkg, frac_if and the fraction_add_reduce RTL.
`timescale 1ns / 1ps

module tb_fraction_add_reduce;

    localparam int W         = frac_pkg::FRAC_OPERAND_WIDTH;
    localparam int NUM_BITS  = 2 * W - 1;
    localparam int DEN_BITS  = 2 * W - 2;
    localparam longint unsigned NUM_MAX = (64'd1 << NUM_BITS) - 64'd1;
    localparam longint unsigned DEN_MAX = (64'd1 << DEN_BITS) - 64'd1;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 160;
    localparam int REPORT_LIMIT = 40;
    // no idling on either side within this window of transfers
    localparam int STEADY_FIRST = 600;
    localparam int STEADY_LAST  = 800;

    typedef struct {
        logic signed [W-1:0] num_a;
        logic signed [W-1:0] den_a;
        logic signed [W-1:0] num_b;
        logic signed [W-1:0] den_b;
    } t_operands;

    typedef struct {
        logic                negative;
        logic [NUM_BITS-1:0] num_mag;
        logic [DEN_BITS-1:0] den_mag;
        logic                den_error;
    } t_reduced;

    logic clk;
    logic rst_n;

    frac_in_if  #(.OPERAND_WIDTH(W)) operands_if ();
    frac_out_if #(.OPERAND_WIDTH(W)) result_if ();

    fraction_add_reduce #(
        .OPERAND_WIDTH(W)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_operands (operands_if),
        .o_result   (result_if)
    );

    t_operands operand_q[$];
    t_reduced  expected_sums[$];
    t_operands next_operands;
    t_operands sent_operands;
    t_reduced  want;
    int        transfers_in;
    int        transfers_out;
    int        mismatches;

    // Clock and reset
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        operands_if.valid = 1'b0;
        operands_if.num_a = '0;
        operands_if.den_a = '0;
        operands_if.num_b = '0;
        operands_if.den_b = '0;
        result_if.ready   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic longint unsigned magnitude(logic signed [W-1:0] v);
        longint s;
        s = v;
        return (s < 0) ? longint'(-s) : s;
    endfunction

    // Sum of the two normalised fractions, reduced by the Euclidean gcd
    function automatic t_reduced reduced_sum(t_operands op);
        longint unsigned na, da, nb, db, t1, t2, den, total, x, y, r, rn, rd;
        logic            neg_a, neg_b, neg;
        t_reduced        res;
        res.negative  = 1'b0;
        res.num_mag   = '0;
        res.den_mag   = '0;
        res.den_error = 1'b0;
        na = magnitude(op.num_a);
        da = magnitude(op.den_a);
        nb = magnitude(op.num_b);
        db = magnitude(op.den_b);
        if (da == 0 || db == 0) begin
            res.den_error = 1'b1;
            return res;
        end
        neg_a = (na != 0) && ((op.num_a < 0) != (op.den_a < 0));
        neg_b = (nb != 0) && ((op.num_b < 0) != (op.den_b < 0));
        t1  = na * db;
        t2  = nb * da;
        den = da * db;
        if (neg_a == neg_b) begin
            total = t1 + t2;
            neg   = neg_a;
        end else if (t1 >= t2) begin
            total = t1 - t2;
            neg   = neg_a;
        end else begin
            total = t2 - t1;
            neg   = neg_b;
        end
        if (total == 0)
            neg = 1'b0;
        x = total;
        y = den;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        rn = total / x;
        rd = den / x;
        if (rn > NUM_MAX)
            rn = NUM_MAX;
        if (rd > DEN_MAX)
            rd = DEN_MAX;
        res.negative = neg;
        res.num_mag  = rn[NUM_BITS-1:0];
        res.den_mag  = rd[DEN_BITS-1:0];
        return res;
    endfunction

    function automatic bit idle_now(int done);
        if (done >= STEADY_FIRST && done < STEADY_LAST)
            return 1'b0;
        return $urandom_range(99) < 16;
    endfunction

    // Mostly full-range or small values, with extremes and powers of two mixed in
    function automatic logic signed [W-1:0] random_field();
        int mode;
        int pick;
        mode = $urandom_range(9);
        if (mode <= 3)
            return W'($urandom);
        if (mode <= 7)
            return W'($urandom_range(80) - 40);
        if (mode == 8) begin
            pick = $urandom_range(5);
            case (pick)
                0: return {1'b1, {(W-1){1'b0}}};
                1: return {1'b1, {(W-2){1'b0}}, 1'b1};
                2: return '1;
                3: return '0;
                4: return W'(1);
                default: return {1'b0, {(W-1){1'b1}}};
            endcase
        end
        pick = $urandom_range(W - 2);
        return ($urandom_range(1) != 0) ? W'(-(1 << pick)) : W'(1 << pick);
    endfunction

    function automatic t_operands make_operands(int na, int da, int nb, int db);
        t_operands op;
        op.num_a = W'(na);
        op.den_a = W'(da);
        op.num_b = W'(nb);
        op.den_b = W'(db);
        return op;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < REPORT_LIMIT)
            $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Operand driver: advance on each transfer, hold the payload while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            operands_if.valid <= 1'b0;
            operands_if.num_a <= '0;
            operands_if.den_a <= '0;
            operands_if.num_b <= '0;
            operands_if.den_b <= '0;
            transfers_in      <= 0;
        end else begin
            if (operands_if.valid && operands_if.ready) begin
                sent_operands.num_a = operands_if.num_a;
                sent_operands.den_a = operands_if.den_a;
                sent_operands.num_b = operands_if.num_b;
                sent_operands.den_b = operands_if.den_b;
                expected_sums.push_back(reduced_sum(sent_operands));
                transfers_in <= transfers_in + 1;
            end
            if (!operands_if.valid || operands_if.ready) begin
                if (operand_q.size() != 0 && !idle_now(transfers_in)) begin
                    next_operands = operand_q.pop_front();
                    operands_if.valid <= 1'b1;
                    operands_if.num_a <= next_operands.num_a;
                    operands_if.den_a <= next_operands.den_a;
                    operands_if.num_b <= next_operands.num_b;
                    operands_if.den_b <= next_operands.den_b;
                end else begin
                    operands_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer against the oldest expected sum
    always @(posedge clk) begin
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            transfers_out   <= 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                transfers_out <= transfers_out + 1;
                if (expected_sums.size() == 0) begin
                    report_mismatch("result transfer with no sum outstanding");
                end else begin
                    want = expected_sums.pop_front();
                    if (result_if.negative !== want.negative)
                        report_mismatch($sformatf("negative got %0b want %0b",
                            result_if.negative, want.negative));
                    if (result_if.num_mag !== want.num_mag)
                        report_mismatch($sformatf("num_mag got %0d want %0d",
                            result_if.num_mag, want.num_mag));
                    if (result_if.den_mag !== want.den_mag)
                        report_mismatch($sformatf("den_mag got %0d want %0d",
                            result_if.den_mag, want.den_mag));
                    if (result_if.den_error !== want.den_error)
                        report_mismatch($sformatf("den_error got %0b want %0b",
                            result_if.den_error, want.den_error));
                end
            end
            result_if.ready <= !idle_now(transfers_out);
        end
    end

    // Stimulus and end of run
    initial begin
        mismatches = 0;
        // simple sums, zero sum and zero numerators
        operand_q.push_back(make_operands(1, 2, 1, 2));
        operand_q.push_back(make_operands(1, 2, -1, 2));
        operand_q.push_back(make_operands(0, 5, 0, -7));
        // zero denominators
        operand_q.push_back(make_operands(3, 0, 1, 2));
        operand_q.push_back(make_operands(1, 2, 3, 0));
        operand_q.push_back(make_operands(0, 0, 0, 0));
        // field extremes
        operand_q.push_back(make_operands(32767, 32767, 32767, 32767));
        operand_q.push_back(make_operands(-32767, 32767, 32767, -32767));
        operand_q.push_back(make_operands(32767, 1, 32767, 1));
        operand_q.push_back(make_operands(1, 32767, 1, 32766));
        operand_q.push_back(make_operands(-32767, 1, 32767, -1));
        // most negative operand taken by its true magnitude
        operand_q.push_back(make_operands(-32768, 1, -32768, 1));
        operand_q.push_back(make_operands(-32768, -32768, 1, -32768));
        operand_q.push_back(make_operands(1, -32768, 1, 32767));
        operand_q.push_back(make_operands(32767, -32768, -32767, 32767));
        operand_q.push_back(make_operands(-32768, -32768, -32768, -32768));
        operand_q.push_back(make_operands(-32768, 32767, 32767, -32768));
        // negative denominators and mixed sign combinations
        operand_q.push_back(make_operands(-5, -10, 7, -3));
        operand_q.push_back(make_operands(5, -10, -7, 3));
        operand_q.push_back(make_operands(-1, 1, -1, 1));
        operand_q.push_back(make_operands(1, 3, -1, 2));
        operand_q.push_back(make_operands(12345, -1, -12345, -1));
        // reduction by a common factor and a cancelling pair
        operand_q.push_back(make_operands(6, 4, 9, 6));
        operand_q.push_back(make_operands(1, 32767, -1, 32767));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            next_operands.num_a = random_field();
            next_operands.den_a = random_field();
            next_operands.num_b = random_field();
            next_operands.den_b = random_field();
            operand_q.push_back(next_operands);
        end

        @(posedge rst_n);
        do
            @(negedge clk);
        while (operand_q.size() != 0 || operands_if.valid || expected_sums.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("tb_fraction_add_reduce passed");
        end else begin
            $display("tb_fraction_add_reduce failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #10_000_000;
        $display("tb_fraction_add_reduce failed");
        $finish;
    end

endmodule
